FILE: hdl/adq_pkg.sv
// Package for the audio DAC double-buffer queue.
// Holds opcodes, status codes, clock constants and the controller/datapath structs.
// No dependencies.
package adq_pkg;

  localparam int unsigned DEFAULT_DEPTH    = 2;
  localparam int unsigned LEN_W            = 18;
  localparam int unsigned RATE_W           = 24;
  localparam int unsigned CNT_W            = 32;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned DIV_W            = 27;
  localparam int unsigned DUE_W            = 21;
  localparam int unsigned REM_W            = 6;
  localparam int unsigned QTR_W            = DUE_W - 2;
  localparam int unsigned RECIP_W          = 20;
  localparam int unsigned RECIP_SHIFT      = 23;

  localparam logic [DIV_W-1:0]  DAC_BASE_CLK = 27'd48681812;
  localparam logic [DIV_W-1:0]  MIN_DIVIDER  = 27'd132;
  localparam logic [RATE_W-1:0] DEFAULT_RATE = 24'd22050;
  // ceil(2^23 / 15); exact division by 15 for any 19-bit dividend.
  localparam logic [RECIP_W-1:0] RECIP_15    = 20'd559241;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOREF  = 2'd2;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_TICK   = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_UNDERRUN = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    DIV_DIVIDER = 2'd0,
    DIV_ACHIEVED = 2'd1
  } div_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SUBMIT,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_DUE,
    S_REM,
    S_DRAIN,
    S_SUM,
    S_DONE
  } state_e;

  typedef struct packed {
    logic     decode;
    logic     submit;
    logic     div_go;
    div_sel_e div_sel;
    logic     due_calc;
    logic     rem_calc;
    logic     drain;
    logic     sum;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic div_done;
    logic drain_done;
    logic sum_done;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/adq_div.sv
// Restoring divider, one quotient bit per cycle, shared by the tick rate divisions.
// Depends on adq_pkg for the operand width.
module adq_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [adq_pkg::DIV_W-1:0] num_i,
  input  logic [adq_pkg::DIV_W-1:0] den_i,
  output logic                     done_o,
  output logic [adq_pkg::DIV_W-1:0] quo_o
);
  import adq_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  den_q, den_d;
  logic [DIV_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/adq_datapath.sv
// Datapath: configuration, queue entries, counters, divider and result register.
// Depends on adq_pkg and adq_div.
module adq_datapath #(
  parameter int unsigned QUEUE_DEPTH = adq_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [adq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adq_pkg::RATE_W-1:0]    cfg_data_i,
  input  logic                          accept_i,
  input  logic [1:0]                    op_i,
  input  logic [adq_pkg::LEN_W-1:0]     length_i,
  input  logic                          out_stall_i,
  input  adq_pkg::cmd_t                 cmd_i,
  output adq_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [adq_pkg::CNT_W-1:0]     length_read_o,
  output logic [1:0]                    queue_occupancy_o,
  output logic [adq_pkg::CNT_W-1:0]     submit_count_o,
  output logic [adq_pkg::CNT_W-1:0]     refused_count_o,
  output logic [adq_pkg::CNT_W-1:0]     underrun_count_o
);
  import adq_pkg::*;

  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PROD_W = QTR_W + RECIP_W;
  localparam logic [OCC_W-1:0] DEPTH_C = OCC_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_C  = IDX_W'(QUEUE_DEPTH - 1);

  logic [RATE_W-1:0] req_q;
  logic              total_q, noref_q;

  op_e               op_q;
  logic [LEN_W-1:0]  len_q;
  logic [CNT_W-1:0]  owed_q [QUEUE_DEPTH];
  logic [OCC_W-1:0]  occ_q;
  logic [REM_W-1:0]  drem_q;
  logic [CNT_W-1:0]  subs_q, refs_q, unds_q;
  logic [DIV_W-1:0]  divr_q;
  logic [DIV_W-1:0]  rate_q;
  logic [DUE_W-1:0]  due_q;
  logic [CNT_W-1:0]  sum_q;
  logic [OCC_W-1:0]  idx_q;
  status_e           st_q;

  logic              out_valid_q;
  logic [1:0]        status_out_q;
  logic [CNT_W-1:0]  rd_out_q;
  logic [1:0]        occ_out_q;
  logic [CNT_W-1:0]  subs_out_q, refs_out_q, unds_out_q;

  logic [RATE_W-1:0] req_eff;
  logic [DIV_W-1:0]  div_num, div_den, quo;
  logic              div_done;
  logic [DUE_W-1:0]  acc, rem_full;
  logic [PROD_W-1:0] due_prod;
  logic [OCC_W-1:0]  sum_lim;
  logic [OCC_W+1:0]  occ_ext;
  logic [CNT_W:0]    sum_add, last_add;
  logic [CNT_W-1:0]  head;
  logic              head_gt;

  assign req_eff = (req_q == '0) ? DEFAULT_RATE : req_q;

  always_comb begin
    div_num = DAC_BASE_CLK;
    div_den = divr_q;
    case (cmd_i.div_sel)
      DIV_DIVIDER: begin
        div_num = DIV_W'({DAC_BASE_CLK, 1'b0}) + DIV_W'(req_eff);
        div_den = DIV_W'({req_eff, 1'b0});
      end
      DIV_ACHIEVED: begin
        div_num = DAC_BASE_CLK;
        div_den = divr_q;
      end
      default: begin
        div_num = DAC_BASE_CLK;
        div_den = divr_q;
      end
    endcase
  end

  adq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Bytes due are acc / 60: drop two bits, then multiply by the reciprocal of 15.
  // The remainder follows in the next state, from the registered due, as acc - 64*due + 4*due.
  assign acc      = DUE_W'({rate_q, 2'b00}) + DUE_W'(drem_q);
  assign due_prod = acc[DUE_W-1:2] * RECIP_15;
  assign rem_full = acc - {due_q[DUE_W-7:0], 6'b000000} + {due_q[DUE_W-3:0], 2'b00};

  // A head-only read is a sum over at most one entry.
  assign sum_lim  = total_q ? occ_q : ((occ_q != '0) ? OCC_W'(1) : '0);
  assign sum_add  = {1'b0, sum_q} + {1'b0, owed_q[idx_q[IDX_W-1:0]]};
  assign last_add = {1'b0, owed_q[LAST_C]} + {{(CNT_W - LEN_W + 1){1'b0}}, len_q};
  assign head     = owed_q[0];
  assign head_gt  = head > CNT_W'(due_q);
  assign occ_ext  = {2'b00, occ_q};

  assign sts_o.op         = op_q;
  assign sts_o.div_done   = div_done;
  assign sts_o.drain_done = (due_q == '0) || (occ_q == '0);
  assign sts_o.sum_done   = idx_q >= sum_lim;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // Configuration and the latched input beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q   <= DEFAULT_RATE;
      total_q <= 1'b0;
      noref_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RATE:  req_q   <= cfg_data_i;
        CFG_TOTAL: total_q <= cfg_data_i[0];
        CFG_NOREF: noref_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      op_q  <= op_e'(op_i);
      len_q <= length_i;
    end
  end

  // Queue entries carry no reset; only occupied entries are ever read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.submit && len_q != '0) begin
      if (occ_q < DEPTH_C) begin
        owed_q[occ_q[IDX_W-1:0]] <= CNT_W'(len_q);
      end else if (noref_q) begin
        owed_q[LAST_C] <= last_add[CNT_W] ? '1 : last_add[CNT_W-1:0];
      end
    end else if (cmd_i.drain && !sts_o.drain_done) begin
      if (head_gt) begin
        owed_q[0] <= head - CNT_W'(due_q);
      end else begin
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          owed_q[i-1] <= owed_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= '0;
      drem_q <= '0;
      subs_q <= '0;
      refs_q <= '0;
      unds_q <= '0;
      st_q   <= ST_OK;
      sum_q  <= '0;
      idx_q  <= '0;
      divr_q <= MIN_DIVIDER;
      rate_q <= '0;
      due_q  <= '0;
    end else begin
      if (cmd_i.decode) begin
        st_q  <= ST_OK;
        sum_q <= '0;
        idx_q <= '0;
      end
      if (cmd_i.submit) begin
        if (len_q == '0) begin
          st_q <= ST_IGNORED;
        end else begin
          if (subs_q != '1) subs_q <= subs_q + 1'b1;
          if (occ_q < DEPTH_C) begin
            occ_q <= occ_q + 1'b1;
          end else if (!noref_q) begin
            st_q <= ST_REFUSED;
            if (refs_q != '1) refs_q <= refs_q + 1'b1;
          end
        end
      end
      if (div_done) begin
        case (cmd_i.div_sel)
          DIV_DIVIDER:  divr_q <= (quo < MIN_DIVIDER) ? MIN_DIVIDER : quo;
          DIV_ACHIEVED: rate_q <= quo;
          default: ;
        endcase
      end
      if (cmd_i.due_calc) begin
        due_q <= DUE_W'(due_prod[PROD_W-1:RECIP_SHIFT]);
      end
      if (cmd_i.rem_calc) begin
        drem_q <= rem_full[REM_W-1:0];
      end
      if (cmd_i.drain) begin
        if (sts_o.drain_done) begin
          if (due_q != '0) begin
            st_q <= ST_UNDERRUN;
            if (unds_q != '1) unds_q <= unds_q + 1'b1;
          end
        end else if (head_gt) begin
          due_q <= '0;
        end else begin
          due_q <= due_q - head[DUE_W-1:0];
          occ_q <= occ_q - 1'b1;
        end
      end
      if (cmd_i.sum && !sts_o.sum_done) begin
        sum_q <= sum_add[CNT_W] ? '1 : sum_add[CNT_W-1:0];
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Result register; the next beat may be accepted while this one waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_out_q <= st_q;
      rd_out_q     <= sum_q;
      occ_out_q    <= occ_ext[1:0];
      subs_out_q   <= subs_q;
      refs_out_q   <= refs_q;
      unds_out_q   <= unds_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_out_q;
  assign length_read_o     = rd_out_q;
  assign queue_occupancy_o = occ_out_q;
  assign submit_count_o    = subs_out_q;
  assign refused_count_o   = refs_out_q;
  assign underrun_count_o  = unds_out_q;

endmodule

FILE: hdl/adq_ctrl.sv
// Controller state machine: sequences submit, the two tick divisions, bytes due,
// remainder, drain and read. Depends on adq_pkg.
module adq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          accept_o,
  input  adq_pkg::sts_t sts_i,
  output adq_pkg::cmd_t cmd_o
);
  import adq_pkg::*;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept_o   = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (accept_o) state_d = S_DECODE;
      S_DECODE: begin
        unique case (sts_i.op)
          OP_SUBMIT: state_d = S_SUBMIT;
          OP_TICK:   state_d = S_DIV1_GO;
          OP_READ:   state_d = S_SUM;
          default:   state_d = S_DONE;
        endcase
      end
      S_SUBMIT:    state_d = S_DONE;
      S_DIV1_GO:   state_d = S_DIV1_WAIT;
      S_DIV1_WAIT: if (sts_i.div_done) state_d = S_DIV2_GO;
      S_DIV2_GO:   state_d = S_DIV2_WAIT;
      S_DIV2_WAIT: if (sts_i.div_done) state_d = S_DUE;
      S_DUE:       state_d = S_REM;
      S_REM:       state_d = S_DRAIN;
      S_DRAIN:     if (sts_i.drain_done) state_d = S_DONE;
      S_SUM:       if (sts_i.sum_done) state_d = S_DONE;
      S_DONE:      if (sts_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_DIVIDER;
    unique case (state_q)
      S_DECODE:    cmd_o.decode = 1'b1;
      S_SUBMIT:    cmd_o.submit = 1'b1;
      S_DIV1_GO:   cmd_o.div_go = 1'b1;
      S_DIV1_WAIT: cmd_o.div_sel = DIV_DIVIDER;
      S_DIV2_GO: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_sel = DIV_ACHIEVED;
      end
      S_DIV2_WAIT: cmd_o.div_sel = DIV_ACHIEVED;
      S_DUE:       cmd_o.due_calc = 1'b1;
      S_REM:       cmd_o.rem_calc = 1'b1;
      S_DRAIN:     cmd_o.drain = 1'b1;
      S_SUM:       cmd_o.sum = 1'b1;
      S_DONE:      cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/audio_dac_double_buffer_queue.sv
// Audio DAC double-buffer queue. A length read sums the head entry or, in total
// mode, every occupied entry; a tick makes two passes of the shared 27-bit divider,
// works out bytes due and the remainder, then drains the queue.
// One beat is in flight, and a new beat is not taken until the last is through; a result
// still stalled at the output holds back loading the next. Reset (asynchronous, active
// low) empties the queue, clears counters and remainder, restores rate and mode bits.
module audio_dac_double_buffer_queue #(
  parameter int unsigned QUEUE_DEPTH = adq_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [adq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adq_pkg::RATE_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [adq_pkg::LEN_W-1:0]     length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [adq_pkg::CNT_W-1:0]     length_read_o,
  output logic [1:0]                    queue_occupancy_o,
  output logic [adq_pkg::CNT_W-1:0]     submit_count_o,
  output logic [adq_pkg::CNT_W-1:0]     refused_count_o,
  output logic [adq_pkg::CNT_W-1:0]     underrun_count_o
);
  import adq_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic accept;

  adq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .accept_o   (accept),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  adq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .accept_i          (accept),
    .op_i              (op_i),
    .length_i          (length_i),
    .out_stall_i       (out_stall_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .length_read_o     (length_read_o),
    .queue_occupancy_o (queue_occupancy_o),
    .submit_count_o    (submit_count_o),
    .refused_count_o   (refused_count_o),
    .underrun_count_o  (underrun_count_o)
  );

endmodule

FILE: tb/tb_audio_dac_double_buffer_queue.sv
// Self-checking testbench for the audio DAC double-buffer queue.
// Predicts each result beat from a local model of the queue and compares it.
// Depends on adq_pkg and the audio_dac_double_buffer_queue RTL.
module tb_audio_dac_double_buffer_queue;
  import adq_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] length_read;
    logic [1:0]  occupancy;
    logic [31:0] submits;
    logic [31:0] refusals;
    logic [31:0] underruns;
  } queue_result_t;

  class queue_scoreboard;
    logic [23:0] rate_req;
    bit          read_total;
    bit          no_refuse;
    logic [31:0] owed [2];
    int unsigned occ;
    int unsigned remainder;
    logic [31:0] submits, refusals, underruns;
    queue_result_t pending[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      rate_req = DEFAULT_RATE;
      read_total = 0;
      no_refuse = 0;
      owed[0] = 0;
      owed[1] = 0;
      occ = 0;
      remainder = 0;
      submits = 0;
      refusals = 0;
      underruns = 0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      if (idx == CFG_RATE) rate_req = val;
      else if (idx == CFG_TOTAL) read_total = val[0];
      else if (idx == CFG_NOREF) no_refuse = val[0];
    endfunction

    function longint unsigned dac_rate();
      longint unsigned req, div;
      req = (rate_req != 0) ? rate_req : DEFAULT_RATE;
      div = (2 * 64'd48681812 + req) / (2 * req);
      if (div < 132) div = 132;
      return 64'd48681812 / div;
    endfunction

    function void note_input(op_e op, logic [17:0] len);
      queue_result_t r;
      longint unsigned acc, due;
      r = '0;
      case (op)
        OP_SUBMIT: begin
          if (len == 0) r.status = ST_IGNORED;
          else begin
            submits = sat_sum(submits, 1);
            if (occ < 2) begin
              owed[occ] = len;
              occ++;
            end else if (!no_refuse) begin
              refusals = sat_sum(refusals, 1);
              r.status = ST_REFUSED;
            end else owed[1] = sat_sum(owed[1], len);
          end
        end
        OP_TICK: begin
          acc = remainder + dac_rate() * 4;
          due = acc / 60;
          remainder = 32'(acc - due * 60);
          while (due > 0 && occ > 0) begin
            if (owed[0] > due) begin
              owed[0] = 32'(owed[0] - due);
              due = 0;
            end else begin
              due -= owed[0];
              owed[0] = owed[1];
              occ--;
            end
          end
          if (due > 0) begin
            underruns = sat_sum(underruns, 1);
            r.status = ST_UNDERRUN;
          end
        end
        OP_READ: begin
          if (occ != 0) begin
            if (!read_total) r.length_read = owed[0];
            else begin
              r.length_read = owed[0];
              if (occ > 1) r.length_read = sat_sum(owed[0], owed[1]);
            end
          end
        end
        default: ;
      endcase
      r.occupancy = 2'(occ);
      r.submits = submits;
      r.refusals = refusals;
      r.underruns = underruns;
      pending.push_back(r);
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t e;
      if (pending.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.length_read !== e.length_read) begin
        $error("length_read exp %0d got %0d", e.length_read, got.length_read); errors++;
      end
      if (got.occupancy !== e.occupancy) begin
        $error("queue_occupancy exp %0d got %0d", e.occupancy, got.occupancy); errors++;
      end
      if (got.submits !== e.submits) begin
        $error("submit_count exp %0d got %0d", e.submits, got.submits); errors++;
      end
      if (got.refusals !== e.refusals) begin
        $error("refused_count exp %0d got %0d", e.refusals, got.refusals); errors++;
      end
      if (got.underruns !== e.underruns) begin
        $error("underrun_count exp %0d got %0d", e.underruns, got.underruns); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [17:0] length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [1:0]  status_o, queue_occupancy_o;
  logic [31:0] length_read_o, submit_count_o, refused_count_o, underrun_count_o;

  queue_scoreboard board = new();
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  bit          calm = 0;

  audio_dac_double_buffer_queue dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Limit: ~870 beats plus output stalls and register waits, with wide margin.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("tb_audio_dac_double_buffer_queue: errors");
      $finish;
    end
  end

  // Result side: stall at random except during the calm stretch.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result({status_o, length_read_o, queue_occupancy_o,
                          submit_count_o, refused_count_o, underrun_count_o});
    out_stall_i <= !calm && ($urandom_range(99) < 10);
  end

  // Valid stays high after a beat is taken so that back-to-back beats need no gap;
  // a random gap or a register write drops it.
  task automatic send_beat(op_e op, logic [17:0] len);
    bit gap;
    gap = !calm && ($urandom_range(99) < 10);
    if (gap) begin
      in_valid_i <= 0;
      do @(posedge clk_i); while (!calm && $urandom_range(99) < 10);
    end
    in_valid_i <= 1;
    op_i <= op;
    length_i <= len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(op, len);
    beats_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
    cfg_we_i <= 0;
  endtask

  // Mostly submits and ticks that keep the queue cycling, with reads mixed in.
  task automatic random_phase(int unsigned count);
    int unsigned k, pick;
    logic [17:0] len;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      len = ($urandom_range(3) == 0) ? 18'($urandom) : 18'($urandom_range(4000));
      if (pick < 40) send_beat(OP_SUBMIT, ($urandom_range(19) == 0) ? 18'd0 : len);
      else if (pick < 70) send_beat(OP_TICK, 18'($urandom));
      else if (pick < 95) send_beat(OP_READ, 18'($urandom));
      else send_beat(OP_NONE, 18'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: ignored zero length, fill, refuse, reads, drain to underrun, total and no-refuse modes, rates.
    send_beat(OP_SUBMIT, 18'd0);
    send_beat(OP_READ, 18'd0);
    send_beat(OP_TICK, 18'd0);
    send_beat(OP_SUBMIT, 18'h3FFFF);
    send_beat(OP_SUBMIT, 18'd1);
    send_beat(OP_SUBMIT, 18'd500);
    send_beat(OP_READ, 18'h3FFFF);
    send_beat(OP_TICK, 18'd0);
    send_beat(OP_READ, 18'd0);
    send_beat(OP_NONE, 18'h2AAAA);
    write_reg(CFG_TOTAL, 24'd1);
    write_reg(CFG_NOREF, 24'd1);
    send_beat(OP_SUBMIT, 18'd100);
    send_beat(OP_SUBMIT, 18'h3FFFF);
    send_beat(OP_SUBMIT, 18'h3FFFF);
    send_beat(OP_READ, 18'd0);
    write_reg(CFG_RATE, 24'hFFFFFF);
    send_beat(OP_TICK, 18'd0);
    write_reg(CFG_RATE, 24'd0);
    send_beat(OP_TICK, 18'd0);
    send_beat(OP_TICK, 18'd0);
    send_beat(OP_TICK, 18'd0);
    send_beat(OP_READ, 18'd0);

    random_phase(200);
    write_reg(CFG_RATE, 24'd1);
    write_reg(CFG_NOREF, 24'd0);
    calm = 1;
    random_phase(150);
    calm = 0;
    write_reg(CFG_RATE, 24'($urandom));
    write_reg(CFG_TOTAL, 24'd0);
    random_phase(250);
    write_reg(CFG_RATE, 24'd44100);
    write_reg(CFG_NOREF, 24'd1);
    write_reg(CFG_TOTAL, 24'd1);
    random_phase(250);

    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("Sent %0d beats, checked %0d results across several rate and mode settings.",
             beats_sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_audio_dac_double_buffer_queue: clean");
    else
      $display("tb_audio_dac_double_buffer_queue: errors");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/adq_pkg.sv
hdl/adq_div.sv
hdl/adq_datapath.sv
hdl/adq_ctrl.sv
hdl/audio_dac_double_buffer_queue.sv
tb/tb_audio_dac_double_buffer_queue.sv
